### hdl/apr_pkg.sv
package apr_pkg;

	localparam int MAX_FRAMES = 128;
	localparam int AGE_BITS   = 32;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

	localparam logic [7:0]          CFG_RESET = 8'd128;
	localparam logic [AGE_BITS-1:0] AGE_TOP   = {1'b1, {(AGE_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		REQ_REF    = 2'd0,
		REQ_VICTIM = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef struct packed {
		logic ref_set;
		logic age_clr;
		logic reduce;
		logic load;
		logic issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic hand_ge_n;
		logic last_issue;
	} status_t;

endpackage

### hdl/apr_ctrl.sv
module apr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       req_type,
	input  apr_pkg::status_t status,
	output apr_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             result_valid
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req_type)
						apr_pkg::REQ_REF:    cmd.ref_set = 1'b1;
						apr_pkg::REQ_CLEAR:  cmd.age_clr = 1'b1;
						apr_pkg::REQ_VICTIM: state_d = ST_PREP;
						default:             ;
					endcase
				end
			end
			ST_PREP: begin
				// bring the hand below the frame count before the scan starts
				if (status.hand_ge_n) begin
					cmd.reduce = 1'b1;
				end else begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DONE);

endmodule

### hdl/apr_datapath.sv
module apr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apr_pkg::cmd_t                 cmd,
	output apr_pkg::status_t              status,
	input  logic [6:0]                    frame_index,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_data,
	output logic [6:0]                    evict_frame,
	output logic [31:0]                   victim_age
);

	localparam int FW = apr_pkg::FRAME_W;
	localparam int CW = apr_pkg::CNT_W;
	localparam int AW = apr_pkg::AGE_BITS;

	logic [7:0]                       cfg_q;
	logic [FW-1:0]                    hand_q;
	logic [FW-1:0]                    pos_q;
	logic [CW-1:0]                    idx_q;
	logic [apr_pkg::MAX_FRAMES-1:0]   ref_q;
	logic [apr_pkg::MAX_FRAMES-1:0]   aval_q;
	logic [FW-1:0]                    best_frame_q;
	logic [AW-1:0]                    best_age_q;

	logic                             vld_s1;
	logic [FW-1:0]                    pos_s1;
	logic                             first_s1;
	logic [AW-1:0]                    rd_s1;

	logic [AW-1:0]                    age_mem [apr_pkg::MAX_FRAMES];

	logic [CW-1:0]                    n_c;
	logic [FW-1:0]                    fidx_c;
	logic                             fidx_ok_c;
	logic [AW-1:0]                    cur_age_c;
	logic [AW-1:0]                    new_age_c;
	logic                             take_c;

	// frame count clamped into 1..MAX_FRAMES
	always_comb begin
		if (cfg_q == 8'd0) begin
			n_c = CW'(1);
		end else if (32'(cfg_q) > apr_pkg::MAX_FRAMES) begin
			n_c = CW'(apr_pkg::MAX_FRAMES);
		end else begin
			n_c = CW'(cfg_q);
		end
	end

	assign fidx_c    = FW'(frame_index);
	assign fidx_ok_c = (32'(frame_index) < apr_pkg::MAX_FRAMES);

	assign status.hand_ge_n  = (CW'(hand_q) >= n_c);
	assign status.last_issue = (idx_q == n_c - CW'(1));

	// a frame whose age was never written or was cleared reads as zero
	assign cur_age_c = aval_q[pos_s1] ? rd_s1 : '0;
	assign new_age_c = (cur_age_c >> 1) | (ref_q[pos_s1] ? apr_pkg::AGE_TOP : '0);
	assign take_c    = first_s1 || (new_age_c < best_age_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= apr_pkg::CFG_RESET;
			hand_q <= '0;
			pos_q  <= '0;
			idx_q  <= '0;
			vld_s1 <= 1'b0;
			ref_q  <= '0;
			aval_q <= '0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (cmd.ref_set && fidx_ok_c) begin
				ref_q[fidx_c] <= 1'b1;
			end
			if (cmd.age_clr && fidx_ok_c) begin
				aval_q[fidx_c] <= 1'b0;
			end
			if (cmd.reduce) begin
				hand_q <= hand_q - FW'(n_c);
			end
			if (cmd.load) begin
				pos_q <= hand_q;
				idx_q <= '0;
			end
			if (cmd.issue) begin
				// advance and wrap at the frame count
				if (CW'(pos_q) + CW'(1) == n_c) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + FW'(1);
				end
				idx_q <= idx_q + CW'(1);
			end
			if (vld_s1) begin
				ref_q[pos_s1]  <= 1'b0;
				aval_q[pos_s1] <= 1'b1;
			end
			if (cmd.finish) begin
				if (CW'(best_frame_q) + CW'(1) == n_c) begin
					hand_q <= '0;
				end else begin
					hand_q <= best_frame_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1   <= pos_q;
		first_s1 <= (idx_q == '0);
		rd_s1    <= age_mem[pos_q];
		if (vld_s1) begin
			age_mem[pos_s1] <= new_age_c;
			if (take_c) begin
				best_age_q   <= new_age_c;
				best_frame_q <= pos_s1;
			end
		end
	end

	assign evict_frame = 7'(best_frame_q);
	assign victim_age  = 32'(best_age_q);

endmodule

### hdl/aging_page_replacement.sv
// Channel   Handshake                  Payload
// request   start, busy                req_type, frame_index
// result    result_valid (strobe)      evict_frame, victim_age
// config    cfg_valid, cfg_ready       frames_in_use
//
// Reference and clear requests are taken in the idle state. A victim request
// first subtracts the frame count from the hand while the count shrank below
// it, then scans n frames, n being the clamped frame count, one frame a cycle
// through the age memory, one read and one write a cycle. Reset clears
// flags, ages and hand at once. The result strobe lasts one cycle and
// cannot be held off.
module aging_page_replacement (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [6:0]  frame_index,
	output logic        result_valid,
	output logic [6:0]  evict_frame,
	output logic [31:0] victim_age,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  frames_in_use
);

	apr_pkg::cmd_t    cmd;
	apr_pkg::status_t status;

	assign cfg_ready = !busy;

	apr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	apr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.frame_index  (frame_index),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (frames_in_use),
		.evict_frame  (evict_frame),
		.victim_age   (victim_age)
	);

endmodule

### verif/tb_aging_page_replacement.sv
`timescale 1ns / 100ps

module tb_aging_page_replacement;

	typedef struct packed {
		logic [apr_pkg::FRAME_W-1:0]  frame;
		logic [apr_pkg::AGE_BITS-1:0] age;
	} victim_t;

	// Tracks frame ages, referenced flags and the hand; queues the victim each
	// selection request should return.
	class victim_scoreboard;
		logic [apr_pkg::AGE_BITS-1:0] age [apr_pkg::MAX_FRAMES];
		bit                           referenced [apr_pkg::MAX_FRAMES];
		int unsigned                  hand;
		logic [7:0]                   frames_cfg;
		victim_t                      victim_q[$];
		int unsigned                  mismatches;
		int unsigned                  checked;

		function new();
			foreach (age[i]) begin
				age[i] = '0;
				referenced[i] = 1'b0;
			end
			hand = 0;
			frames_cfg = apr_pkg::CFG_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function int unsigned pending();
			return victim_q.size();
		endfunction

		function void note(apr_pkg::req_t kind, logic [apr_pkg::FRAME_W-1:0] idx);
			int unsigned n, first, pos, best;
			logic [apr_pkg::AGE_BITS-1:0] best_age;
			victim_t v;
			case (kind)
			apr_pkg::REQ_REF: referenced[idx] = 1'b1;
			apr_pkg::REQ_CLEAR: age[idx] = '0;
			apr_pkg::REQ_VICTIM: begin
				// zero counts as one, anything past the table as the table size
				if (frames_cfg == 0)
					n = 1;
				else if (frames_cfg > apr_pkg::MAX_FRAMES)
					n = apr_pkg::MAX_FRAMES;
				else
					n = frames_cfg;
				first = hand % n;
				best = first;
				best_age = '0;
				for (int i = 0; i < n; i++) begin
					pos = (first + i) % n;
					age[pos] = age[pos] >> 1;
					if (referenced[pos]) begin
						age[pos] = age[pos] | apr_pkg::AGE_TOP;
						referenced[pos] = 1'b0;
					end
					// strict compare: first frame in scan order wins a tie
					if (i == 0 || age[pos] < best_age) begin
						best_age = age[pos];
						best = pos;
					end
				end
				hand = (best + 1) % n;
				v.frame = apr_pkg::FRAME_W'(best);
				v.age = best_age;
				victim_q.push_back(v);
			end
			default: ;
			endcase
		endfunction

		function void check(logic [apr_pkg::FRAME_W-1:0] frame,
				logic [apr_pkg::AGE_BITS-1:0] age_seen);
			victim_t want;
			if (victim_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: victim frame %0d age %h with no request outstanding",
						$realtime, frame, age_seen);
				return;
			end
			want = victim_q.pop_front();
			checked++;
			if (frame !== want.frame || age_seen !== want.age) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: victim mismatch: frame exp %0d got %0d, age exp %h got %h",
						$realtime, want.frame, frame, want.age, age_seen);
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [1:0]                   req_type;
	logic [apr_pkg::FRAME_W-1:0]  frame_index;
	logic                         result_valid;
	logic [apr_pkg::FRAME_W-1:0]  evict_frame;
	logic [apr_pkg::AGE_BITS-1:0] victim_age;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [7:0]                   frames_in_use;

	victim_scoreboard board = new();
	bit               no_idle;
	int unsigned      requests_sent;
	int unsigned      count_writes;

	aging_page_replacement DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.frame_index  (frame_index),
		.result_valid (result_valid),
		.evict_frame  (evict_frame),
		.victim_age   (victim_age),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.frames_in_use(frames_in_use)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check(evict_frame, victim_age);
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d victims outstanding", board.pending());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	// Hold the request until a transfer, then idle for a random gap.
	task automatic issue(apr_pkg::req_t kind, logic [apr_pkg::FRAME_W-1:0] idx);
		int gap;
		start <= 1'b1;
		req_type <= kind;
		frame_index <= idx;
		do @(posedge clk); while (busy);
		board.note(kind, idx);
		if (kind != apr_pkg::REQ_NONE)
			requests_sent++;
		gap = idle_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_frame_count(logic [7:0] value);
		drain();
		cfg_valid <= 1'b1;
		frames_in_use <= value;
		do @(posedge clk); while (!cfg_ready);
		board.frames_cfg = value;
		cfg_valid <= 1'b0;
		count_writes++;
	endtask

	function automatic logic [7:0] pick_count();
		case ($urandom_range(9))
		0: return 8'd1;
		1: return 8'd2;
		2: return 8'd3;
		3: return 8'd5;
		4: return 8'd0;
		5: return 8'($urandom_range(20, 4));
		6: return 8'($urandom_range(127, 21));
		7: return 8'd128;
		8: return 8'd255;
		default: return 8'($urandom_range(254, 129));
		endcase
	endfunction

	initial begin
		int                          phase_len;
		int                          r;
		int unsigned                 span;
		logic [7:0]                  cnt;
		apr_pkg::req_t               kind;
		logic [apr_pkg::FRAME_W-1:0] idx;

		start <= 1'b0;
		req_type <= apr_pkg::REQ_REF;
		frame_index <= '0;
		cfg_valid <= 1'b0;
		frames_in_use <= apr_pkg::CFG_RESET;
		arst_n <= 1'b0;
		no_idle = 1'b0;
		requests_sent = 0;
		count_writes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset table: all ages zero, so the scan start wins
		issue(apr_pkg::REQ_VICTIM, 7'd0);
		issue(apr_pkg::REQ_REF, 7'd0);
		issue(apr_pkg::REQ_REF, 7'd127);
		issue(apr_pkg::REQ_NONE, 7'd127);
		issue(apr_pkg::REQ_VICTIM, 7'd127);
		issue(apr_pkg::REQ_REF, 7'd2);
		issue(apr_pkg::REQ_REF, 7'd3);
		issue(apr_pkg::REQ_REF, 7'd1);
		issue(apr_pkg::REQ_VICTIM, 7'd85);
		issue(apr_pkg::REQ_CLEAR, 7'd127);
		issue(apr_pkg::REQ_CLEAR, 7'd0);
		// hand now sits past a three-frame table
		set_frame_count(8'd3);
		issue(apr_pkg::REQ_VICTIM, 7'd42);
		set_frame_count(8'd0);
		issue(apr_pkg::REQ_REF, 7'd0);
		issue(apr_pkg::REQ_VICTIM, 7'd0);
		issue(apr_pkg::REQ_VICTIM, 7'd127);
		set_frame_count(8'd255);
		issue(apr_pkg::REQ_REF, 7'd127);
		issue(apr_pkg::REQ_REF, 7'd64);
		issue(apr_pkg::REQ_VICTIM, 7'd1);
		set_frame_count(8'd128);
		issue(apr_pkg::REQ_CLEAR, 7'd64);
		issue(apr_pkg::REQ_VICTIM, 7'd63);

		while (requests_sent < 950) begin
			cnt = pick_count();
			set_frame_count(cnt);
			span = (cnt == 0) ? 1 : (cnt > apr_pkg::MAX_FRAMES) ? apr_pkg::MAX_FRAMES : cnt;
			no_idle = ($urandom_range(3) == 0);
			phase_len = $urandom_range(180, 60);
			for (int k = 0; k < phase_len && requests_sent < 950; k++) begin
				r = $urandom_range(99);
				if (r < 50)
					kind = apr_pkg::REQ_REF;
				else if (r < 70)
					kind = apr_pkg::REQ_VICTIM;
				else if (r < 93)
					kind = apr_pkg::REQ_CLEAR;
				else
					kind = apr_pkg::REQ_NONE;
				// keep most traffic inside the managed frames
				if ($urandom_range(3) != 0)
					idx = apr_pkg::FRAME_W'($urandom_range(span - 1));
				else
					idx = apr_pkg::FRAME_W'($urandom_range(apr_pkg::MAX_FRAMES - 1));
				issue(kind, idx);
			end
		end

		drain();
		repeat (20) @(posedge clk);

		$display("Issued %0d requests over %0d frame-count writes; %0d victims checked.",
			requests_sent, count_writes, board.checked);
		$display("Mismatches: %0d, victims outstanding: %0d",
			board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
